// ===== rtl/tsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed slot pool package
// Sizes, item kinds, controller states, command and status groups and the
// fade color table shared by the slot pool modules.
// ----------------------------------------------------------------------------
package tsp_pkg;

   localparam int SLOTS      = 512;
   localparam int LIFE_BITS  = 10;
   localparam int RAMP_STEPS = 120;

   localparam int SLOT_BITS  = $clog2(SLOTS);
   localparam int CNT_BITS   = $clog2(SLOTS + 1);
   localparam int RAMP_BITS  = $clog2(RAMP_STEPS + 1);
   localparam int LIFE_MAX   = (1 << LIFE_BITS) - 1;

   localparam int KIND_FIELD = 2;
   localparam int LIFE_FIELD = 10;
   localparam int SLOT_FIELD = 9;
   localparam int CHAN_BITS  = 8;
   localparam int LIFE_FIELD_MAX = (1 << LIFE_FIELD) - 1;

   typedef enum logic [KIND_FIELD-1:0] {
      KIND_SPAWN = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_CLEAR,
      ST_QUERY,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic sweep;
      logic query_read;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic cnt_last;
      logic scan_end;
      logic free_hit;
      logic rsp_free;
   } stat_type;

   typedef logic [4*CHAN_BITS-1:0] fade_word_type;
   typedef fade_word_type fade_table_type [RAMP_STEPS+1];

   // Rounded 255 * sqrt(0.6 * n / d), ties up, by a search over the codes.
   function automatic logic [CHAN_BITS-1:0] fade_chan(longint n, longint d);
      longint lim;
      longint o;
      int     k;
      bit     stop;
      lim  = 780300 * n;
      k    = 0;
      stop = 1'b0;
      for (int c = 1; c <= 255; c++) begin
         if (!stop) begin
            o = longint'(2 * c - 1);
            if (o * o * 5 * d <= lim) begin
               k = c;
            end else begin
               stop = 1'b1;
            end
         end
      end
      return CHAN_BITS'(k);
   endfunction

   // Entry layout: red, green, blue, alpha from the top byte down.
   function automatic fade_table_type build_fade_table();
      fade_table_type t;
      longint         l;
      longint         r;
      r = longint'(RAMP_STEPS);
      for (int i = 0; i <= RAMP_STEPS; i++) begin
         l = longint'(i);
         if (2 * l > r) begin
            t[i] = {fade_chan(2 * l - r, r), fade_chan(2 * r - 2 * l, r),
                    CHAN_BITS'(0),
                    CHAN_BITS'((510 * l + RAMP_STEPS) / (2 * RAMP_STEPS))};
         end else begin
            t[i] = {CHAN_BITS'(0), fade_chan(2 * l, r), fade_chan(r - 2 * l, r),
                    CHAN_BITS'((510 * l + RAMP_STEPS) / (2 * RAMP_STEPS))};
         end
      end
      return t;
   endfunction

   localparam fade_table_type FADE_TABLE = build_fade_table();

endpackage

// ===== rtl/tsp_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed slot pool request channel
// Valid/ready channel that carries one item kind, spawn life and slot number.
// ----------------------------------------------------------------------------
interface tsp_req_if import tsp_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [KIND_FIELD-1:0] kind;
   logic [LIFE_FIELD-1:0] life;
   logic [SLOT_FIELD-1:0] slot;

   modport source (output valid, output kind, output life, output slot, input ready);
   modport sink   (input valid, input kind, input life, input slot, output ready);

endinterface

// ===== rtl/tsp_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed slot pool response channel
// Valid/ready channel that carries one result beat of the slot pool.
// ----------------------------------------------------------------------------
interface tsp_rsp_if import tsp_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [SLOT_FIELD-1:0] slot_index;
   logic                  none_free;
   logic                  alive;
   logic [LIFE_FIELD-1:0] life_left;
   logic [CHAN_BITS-1:0]  red;
   logic [CHAN_BITS-1:0]  green;
   logic [CHAN_BITS-1:0]  blue;
   logic [CHAN_BITS-1:0]  alpha;

   modport source (output valid, output slot_index, output none_free, output alive,
                   output life_left, output red, output green, output blue,
                   output alpha, input ready);
   modport sink   (input valid, input slot_index, input none_free, input alive,
                   input life_left, input red, input green, input blue,
                   input alpha, output ready);

endinterface

// ===== rtl/tsp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed slot pool controller
// Sequences the reset clearing pass, the slot scans, the clear sweep, the
// query read and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module tsp_ctrl import tsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [KIND_FIELD-1:0] req_kind,
   output logic                  req_ready,
   input  stat_type              stat,
   output cmd_type               cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep = 1'b1;
            if (stat.cnt_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (kind_type'(req_kind))
                  KIND_SPAWN: state_in = ST_SCAN;
                  KIND_TICK:  state_in = ST_SCAN;
                  KIND_CLEAR: state_in = ST_CLEAR;
                  KIND_QUERY: state_in = ST_QUERY;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.free_hit || stat.scan_end) begin
               state_in = ST_RESULT;
            end
         end
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (stat.cnt_last) begin
               state_in = ST_RESULT;
            end
         end
         ST_QUERY: begin
            cmd.query_read = 1'b1;
            state_in       = ST_RESULT;
         end
         ST_RESULT: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/tsp_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed slot pool datapath
// Alive and life memories with one write and one registered read port, the
// slot counter, the scan pipeline, the fade table and the output register.
// ----------------------------------------------------------------------------
module tsp_dpath import tsp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [KIND_FIELD-1:0] req_kind,
   input  logic [LIFE_FIELD-1:0] req_life,
   input  logic [SLOT_FIELD-1:0] req_slot,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [SLOT_FIELD-1:0] rsp_slot_index,
   output logic                  rsp_none_free,
   output logic                  rsp_alive,
   output logic [LIFE_FIELD-1:0] rsp_life_left,
   output logic [CHAN_BITS-1:0]  rsp_red,
   output logic [CHAN_BITS-1:0]  rsp_green,
   output logic [CHAN_BITS-1:0]  rsp_blue,
   output logic [CHAN_BITS-1:0]  rsp_alpha
);

   logic                 alive_mem_ff [SLOTS];
   logic [LIFE_BITS-1:0] life_mem_ff  [SLOTS];

   kind_type              kind_ff;
   logic [LIFE_FIELD-1:0] life_ff;
   logic [SLOT_FIELD-1:0] slot_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [CNT_BITS-1:0]   cnt_in;
   logic                  pend_vld_ff;
   logic [SLOT_BITS-1:0]  pend_addr_ff;
   logic                  alive_rd_ff;
   logic [LIFE_BITS-1:0]  life_rd_ff;
   logic                  found_ff;
   logic [SLOT_BITS-1:0]  claim_ff;
   logic                  rsp_valid_ff;
   logic [SLOT_FIELD-1:0] slot_index_ff;
   logic                  none_free_ff;
   logic                  alive_ff;
   logic [LIFE_FIELD-1:0] life_left_ff;
   fade_word_type         fade_ff;

   logic [SLOT_FIELD-1:0] slot_index_in;
   logic                  none_free_in;
   logic                  alive_in;
   logic [LIFE_FIELD-1:0] life_left_in;
   fade_word_type         fade_in;

   logic                  scan_rd;
   logic                  rd_en;
   logic [SLOT_BITS-1:0]  rd_addr;
   logic                  alive_we;
   logic                  life_we;
   logic [SLOT_BITS-1:0]  wr_addr;
   logic                  alive_wd;
   logic [LIFE_BITS-1:0]  life_wd;
   logic [LIFE_BITS-1:0]  spawn_life;
   logic                  claim;
   logic                  tick_wr;
   logic                  in_range;
   logic [RAMP_BITS-1:0]  ramp_idx;

   assign scan_rd = cmd.scan && (int'(cnt_ff) != SLOTS);
   assign rd_en   = scan_rd || cmd.query_read;
   assign rd_addr = cmd.query_read ? SLOT_BITS'(slot_ff) : cnt_ff[SLOT_BITS-1:0];

   assign stat.cnt_last = (int'(cnt_ff) == SLOTS - 1);
   assign stat.scan_end = (int'(cnt_ff) == SLOTS) && !pend_vld_ff;
   assign stat.free_hit = (kind_ff == KIND_SPAWN) && pend_vld_ff && !alive_rd_ff;
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   assign claim   = cmd.scan && stat.free_hit;
   assign tick_wr = cmd.scan && (kind_ff == KIND_TICK) && pend_vld_ff && alive_rd_ff;

   assign spawn_life = (int'(life_ff) > LIFE_MAX) ? LIFE_BITS'(LIFE_MAX)
                                                  : LIFE_BITS'(life_ff);

   always_comb begin
      alive_we = 1'b0;
      life_we  = 1'b0;
      wr_addr  = pend_addr_ff;
      alive_wd = 1'b0;
      life_wd  = spawn_life;
      if (cmd.sweep) begin
         alive_we = 1'b1;
         wr_addr  = cnt_ff[SLOT_BITS-1:0];
      end else if (claim) begin
         alive_we = 1'b1;
         life_we  = 1'b1;
         alive_wd = 1'b1;
      end else if (tick_wr) begin
         alive_we = 1'b1;
         life_we  = 1'b1;
         alive_wd = (life_rd_ff > LIFE_BITS'(1));
         life_wd  = (life_rd_ff > LIFE_BITS'(1)) ? life_rd_ff - LIFE_BITS'(1)
                                                 : LIFE_BITS'(0);
      end
   end

   always_ff @(posedge clock) begin
      if (alive_we) begin
         alive_mem_ff[wr_addr] <= alive_wd;
      end
      if (life_we) begin
         life_mem_ff[wr_addr] <= life_wd;
      end
      if (rd_en) begin
         alive_rd_ff <= alive_mem_ff[rd_addr];
         life_rd_ff  <= life_mem_ff[rd_addr];
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.capture) begin
         cnt_in = '0;
      end else if (cmd.sweep || scan_rd) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pend_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         pend_vld_ff <= scan_rd;
         if (cmd.capture) begin
            found_ff <= 1'b0;
         end else if (claim) begin
            found_ff <= 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= cnt_ff[SLOT_BITS-1:0];
      if (cmd.capture) begin
         kind_ff <= kind_type'(req_kind);
         life_ff <= req_life;
         slot_ff <= req_slot;
      end
      if (claim) begin
         claim_ff <= pend_addr_ff;
      end
      if (cmd.load_rsp) begin
         slot_index_ff <= slot_index_in;
         none_free_ff  <= none_free_in;
         alive_ff      <= alive_in;
         life_left_ff  <= life_left_in;
         fade_ff       <= fade_in;
      end
   end

   assign in_range = (int'(slot_ff) < SLOTS);
   assign ramp_idx = (int'(life_rd_ff) > RAMP_STEPS) ? RAMP_BITS'(RAMP_STEPS)
                                                     : RAMP_BITS'(life_rd_ff);

   always_comb begin
      slot_index_in = '0;
      none_free_in  = 1'b0;
      alive_in      = 1'b0;
      life_left_in  = '0;
      fade_in       = '0;
      case (kind_ff)
         KIND_SPAWN: begin
            if (found_ff) begin
               slot_index_in = SLOT_FIELD'(claim_ff);
            end else begin
               none_free_in = 1'b1;
            end
         end
         KIND_QUERY: begin
            slot_index_in = slot_ff;
            if (in_range && alive_rd_ff) begin
               alive_in     = 1'b1;
               life_left_in = (int'(life_rd_ff) > LIFE_FIELD_MAX)
                              ? LIFE_FIELD'(LIFE_FIELD_MAX) : LIFE_FIELD'(life_rd_ff);
               fade_in      = FADE_TABLE[ramp_idx];
            end
         end
         default: begin
            slot_index_in = '0;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = slot_index_ff;
   assign rsp_none_free  = none_free_ff;
   assign rsp_alive      = alive_ff;
   assign rsp_life_left  = life_left_ff;
   assign rsp_red        = fade_ff[4*CHAN_BITS-1:3*CHAN_BITS];
   assign rsp_green      = fade_ff[3*CHAN_BITS-1:2*CHAN_BITS];
   assign rsp_blue       = fade_ff[2*CHAN_BITS-1:CHAN_BITS];
   assign rsp_alpha      = fade_ff[CHAN_BITS-1:0];

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= SLOTS)
      else $error("slot counter ran past the pool size");

   a_pend_follows_cnt: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && pend_vld_ff) |-> (CNT_BITS'(pend_addr_ff) + CNT_BITS'(1) == cnt_ff))
      else $error("scan read data does not belong to the previous counter value");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a beat that was not taken");

   a_found_spawn: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (kind_ff == KIND_SPAWN))
      else $error("claimed slot recorded for an item that is not a spawn");

endmodule

// ===== rtl/timed_slot_pool.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timed slot pool
// Pool of slots with an alive bit and a life count each: spawn claims the
// lowest free slot, tick ages every live slot, clear frees all, query reports
// one slot with its fade color.
//
//   Channel   Modport   Beat
//   req_bus   sink      kind, life, slot
//   rsp_bus   source    slot_index, none_free, alive, life_left, RGBA
//
// Every item gives one result beat. A tick scans and a clear sweeps every slot
// through the slot memories, which have one write and one read port; a spawn
// stops at the first free slot that it finds and a query reads its one slot.
// After reset a clearing pass over all slots runs before the first item.
// The result waits in an output register, and the next item is taken while
// it is stalled there.
// ----------------------------------------------------------------------------
module timed_slot_pool import tsp_pkg::*; (
   input logic       clock,
   input logic       reset,
   tsp_req_if.sink   req_bus,
   tsp_rsp_if.source rsp_bus
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_ready;

   assign req_bus.ready = req_ready;

   tsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tsp_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_bus.kind),
      .req_life       (req_bus.life),
      .req_slot       (req_bus.slot),
      .rsp_ready      (rsp_bus.ready),
      .rsp_valid      (rsp_bus.valid),
      .rsp_slot_index (rsp_bus.slot_index),
      .rsp_none_free  (rsp_bus.none_free),
      .rsp_alive      (rsp_bus.alive),
      .rsp_life_left  (rsp_bus.life_left),
      .rsp_red        (rsp_bus.red),
      .rsp_green      (rsp_bus.green),
      .rsp_blue       (rsp_bus.blue),
      .rsp_alpha      (rsp_bus.alpha)
   );

endmodule
